// File: hw/rtl/nps_pkg.sv
`default_nettype none
package nps_pkg;

    localparam int unsigned BURST_W = 16;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned ARR_W   = 16;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned TIME_W  = 23;
    localparam int unsigned WAIT_W  = 22;
    localparam int unsigned TOTAL_W = 29;
    localparam int unsigned AVG_W   = 30;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned DVD_W   = TOTAL_W + FRAC_W;
    localparam int unsigned DVS_W   = 7;

    typedef struct packed {
        logic                valid;
        logic                done;
        logic [SLOT_W-1:0]   idx;
        logic [BURST_W-1:0]  burst;
        logic [PRIO_W-1:0]   prio;
        logic [ARR_W-1:0]    arr;
        logic [TIME_W-1:0]   start;
        logic [TIME_W-1:0]   finish;
    } proc_rec_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_DECIDE,
        ST_DIV,
        ST_OUT
    } sched_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/nps_if.sv
`default_nettype none
interface nps_in_if;
    import nps_pkg::*;
    logic               valid;
    logic               ready;
    logic [BURST_W-1:0] burst_length;
    logic [PRIO_W-1:0]  prio_level;
    logic [ARR_W-1:0]   arrive_at;
    logic               final_entry;
    modport source (output valid, burst_length, prio_level, arrive_at, final_entry,
                    input ready);
    modport sink   (input valid, burst_length, prio_level, arrive_at, final_entry,
                    output ready);
endinterface

interface nps_out_if;
    import nps_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] proc_slot;
    logic [TIME_W-1:0] begin_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [WAIT_W-1:0] wait_span;
    logic [AVG_W-1:0]  avg_wait_q8;
    logic              last_result;
    modport source (output valid, proc_slot, begin_time, finish_time, turnaround,
                    wait_span, avg_wait_q8, last_result, input ready);
    modport sink   (input valid, proc_slot, begin_time, finish_time, turnaround,
                    wait_span, avg_wait_q8, last_result, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/nps_cell.sv
`default_nettype none
module nps_cell
    import nps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire proc_rec_t  load_rec,
    input  wire proc_rec_t  shift_rec,
    output proc_rec_t       rec
);

    logic      valid_reg, valid_next;
    logic      done_reg, done_next;
    proc_rec_t data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        done_next  = done_reg;
        data_next  = data_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
            done_next  = 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_next = 1'b1;
            done_next  = 1'b0;
            data_next  = load_rec;
        end
        else if (ctrl.shift)
        begin
            valid_next = shift_rec.valid;
            done_next  = shift_rec.done;
            data_next  = shift_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        rec       = data_reg;
        rec.valid = valid_reg;
        rec.done  = done_reg;
    end

endmodule
`default_nettype wire

// File: hw/rtl/nps_div.sv
`default_nettype none
module nps_div
    import nps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// File: hw/rtl/nonpreemptive_priority_scheduler.sv
`default_nettype none
// Channel    Dir  Payload
// proc_in    in   burst_length, prio_level, arrive_at, final_entry
// sched_out  out  proc_slot, begin_time, finish_time, turnaround, wait_span,
//                 avg_wait_q8, last_result
//
// Loading takes one request per cycle into a row of MAX_PROCS cells.
// Each scheduling decision rotates the whole row once past a compare unit at
// its head; one extra pass retires the last pick, then serial
// division forms the average, then one result per cycle while sched_out is
// ready, in load order. proc_in is held off from the final request until the
// last result is taken. Reset empties the row; stalls on sched_out hold the row.
module nonpreemptive_priority_scheduler
    import nps_pkg::*;
#(
    parameter int unsigned MAX_PROCS = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    nps_in_if.sink     proc_in,
    nps_out_if.source  sched_out
);

    localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned CW = $clog2(MAX_PROCS + 1);

    sched_state_t        state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       left_reg, left_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TIME_W-1:0]   clock_reg, clock_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                best_v_reg, best_v_next;
    proc_rec_t           best_reg, best_next;
    logic [ARR_W-1:0]    early_reg, early_next;
    logic                pend_v_reg, pend_v_next;
    logic [SLOT_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [TIME_W-1:0]   pend_start_reg, pend_start_next;
    logic [TIME_W-1:0]   pend_fin_reg, pend_fin_next;
    logic [AVG_W-1:0]    avg_reg;

    proc_rec_t           cell_q [MAX_PROCS];
    proc_rec_t           load_rec;
    proc_rec_t           head;
    proc_rec_t           tail_rec;
    logic                hit;
    logic                better;
    logic                rotate;
    logic                clear_all;
    logic                in_acc;
    logic                out_acc;
    logic                div_start;
    logic                div_done;
    logic [DVD_W-1:0]    quotient;

    assign in_acc  = proc_in.valid && proc_in.ready;
    assign out_acc = sched_out.valid && sched_out.ready;
    assign head    = cell_q[0];

    always_comb
    begin
        load_rec        = '0;
        load_rec.valid  = 1'b1;
        load_rec.idx    = SLOT_W'(count_reg);
        load_rec.burst  = proc_in.burst_length;
        load_rec.prio   = proc_in.prio_level;
        load_rec.arr    = proc_in.arrive_at;
    end

    // retire the previous pick as it passes the head
    always_comb
    begin
        hit      = pend_v_reg && (head.idx == pend_idx_reg);
        tail_rec = head;
        if (hit)
        begin
            tail_rec.done   = 1'b1;
            tail_rec.start  = pend_start_reg;
            tail_rec.finish = pend_fin_reg;
        end
    end

    always_comb
    begin
        if (head.prio != best_reg.prio)
            better = head.prio < best_reg.prio;
        else if (head.burst != best_reg.burst)
            better = head.burst < best_reg.burst;
        else
            better = head.arr < best_reg.arr;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        pos_next        = pos_reg;
        slot_next       = slot_reg;
        clock_next      = clock_reg;
        total_next      = total_reg;
        best_v_next     = best_v_reg;
        best_next       = best_reg;
        early_next      = early_reg;
        pend_v_next     = pend_v_reg;
        pend_idx_next   = pend_idx_reg;
        pend_start_next = pend_start_reg;
        pend_fin_next   = pend_fin_reg;
        rotate          = 1'b0;
        clear_all       = 1'b0;
        div_start       = 1'b0;
        proc_in.ready   = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                proc_in.ready = 1'b1;
                if (in_acc)
                begin
                    if (count_reg != CW'(MAX_PROCS))
                        count_next = count_reg + 1'b1;
                    if (proc_in.final_entry)
                    begin
                        left_next   = count_next;
                        clock_next  = '0;
                        total_next  = '0;
                        pos_next    = '0;
                        best_v_next = 1'b0;
                        early_next  = '1;
                        pend_v_next = 1'b0;
                        state_next  = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                rotate   = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (head.valid && !head.done && !hit)
                begin
                    if ({7'd0, head.arr} <= clock_reg)
                    begin
                        if (!best_v_reg || better)
                        begin
                            best_v_next = 1'b1;
                            best_next   = head;
                        end
                    end
                    else if (head.arr < early_reg)
                    begin
                        early_next = head.arr;
                    end
                end
                if (pos_reg == IW'(MAX_PROCS - 1))
                begin
                    pos_next   = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                pend_v_next = 1'b0;
                if (left_reg == '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    if (best_v_reg)
                    begin
                        pend_v_next     = 1'b1;
                        pend_idx_next   = best_reg.idx;
                        pend_start_next = clock_reg;
                        pend_fin_next   = clock_reg + TIME_W'(best_reg.burst);
                        total_next      = total_reg
                                        + TOTAL_W'(clock_reg - TIME_W'(best_reg.arr));
                        clock_next      = clock_reg + TIME_W'(best_reg.burst);
                        left_next       = left_reg - 1'b1;
                    end
                    else
                    begin
                        clock_next = TIME_W'(early_reg);
                    end
                    best_v_next = 1'b0;
                    early_next  = '1;
                    state_next  = ST_PASS;
                end
            end
            ST_DIV:
            begin
                slot_next = '0;
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    rotate    = 1'b1;
                    slot_next = slot_reg + 1'b1;
                    if (CW'(slot_reg) == count_reg - 1'b1)
                    begin
                        clear_all  = 1'b1;
                        count_next = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++)
        begin : g_cell
            cell_ctrl_t ctrl;
            proc_rec_t  shift_rec;
            always_comb
            begin
                ctrl.clear = clear_all;
                ctrl.load  = in_acc && (count_reg == CW'(g));
                ctrl.shift = rotate;
            end
            if (g == MAX_PROCS - 1)
            begin : g_tail
                assign shift_rec = tail_rec;
            end
            else
            begin : g_mid
                assign shift_rec = cell_q[g + 1];
            end
            nps_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .load_rec  (load_rec),
                .shift_rec (shift_rec),
                .rec       (cell_q[g])
            );
        end
    endgenerate

    nps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({total_reg, FRAC_W'(0)}),
        .divisor  (DVS_W'(count_reg)),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            left_reg   <= '0;
            pos_reg    <= '0;
            slot_reg   <= '0;
            clock_reg  <= '0;
            total_reg  <= '0;
            best_v_reg <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            pos_reg    <= pos_next;
            slot_reg   <= slot_next;
            clock_reg  <= clock_next;
            total_reg  <= total_next;
            best_v_reg <= best_v_next;
            pend_v_reg <= pend_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg       <= best_next;
        early_reg      <= early_next;
        pend_idx_reg   <= pend_idx_next;
        pend_start_reg <= pend_start_next;
        pend_fin_reg   <= pend_fin_next;
        if (div_done)
            avg_reg <= AVG_W'(quotient);
    end

    always_comb
    begin
        sched_out.valid       = (state_reg == ST_OUT);
        sched_out.proc_slot   = head.idx;
        sched_out.begin_time  = head.start;
        sched_out.finish_time = head.finish;
        sched_out.turnaround  = head.finish - TIME_W'(head.arr);
        sched_out.wait_span   = WAIT_W'(head.start - TIME_W'(head.arr));
        sched_out.last_result = (CW'(slot_reg) == count_reg - 1'b1);
        sched_out.avg_wait_q8 = sched_out.last_result ? avg_reg : '0;
    end

endmodule
`default_nettype wire
